>>> hdl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared types and constants of the hsv to rgb colour converter pipeline
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int unsigned NUM_STAGES = 5;

    localparam int unsigned HUE_SPAN   = 360;
    localparam int unsigned SECTOR_DEG = 60;
    localparam int unsigned FULL_SCALE = 255;
    localparam int unsigned SECTOR_DEN = FULL_SCALE * SECTOR_DEG;   // 15300

    // floor(x/255) = (x * 0x8081) >> 23, exact for any 16-bit x
    localparam int unsigned RECIP_255   = 32'h0000_8081;
    localparam int unsigned SHIFT_255   = 23;
    // 15300 = 4 * 3825, the factor of four is a plain shift
    localparam int unsigned QUARTER_DEN = SECTOR_DEN / 4;           // 3825
    localparam int unsigned RECIP_QD    = 1122867;                  // floor(2^32 / 3825)
    localparam int unsigned SHIFT_QD    = 32;

    typedef logic [7:0] t_chan;
    typedef logic [2:0] t_sector;

    // sector codes, named after the pair of primaries/secondaries they span
    localparam t_sector SEC_RED_YEL = 3'd0;
    localparam t_sector SEC_YEL_GRN = 3'd1;
    localparam t_sector SEC_GRN_CYN = 3'd2;
    localparam t_sector SEC_CYN_BLU = 3'd3;
    localparam t_sector SEC_BLU_MAG = 3'd4;
    localparam t_sector SEC_MAG_RED = 3'd5;

    // after hue split
    typedef struct packed {
        logic    ok;
        t_sector sector;
        logic [5:0] rem;
        t_chan   sat;
        t_chan   val;
    } t_s1;

    // after the second multiply stage
    typedef struct packed {
        logic    ok;
        t_sector sector;
        t_chan   val;
        t_chan   m;
        logic [21:0] prod_n;
        logic [21:0] prod_k;
    } t_s3;

endpackage

>>> hdl/hsv2rgb_sector.sv
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// splits the hue into a 60 degree sector and the offset inside it
// ----------------------------------------------------------------------------
module hsv2rgb_sector (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [8:0]           i_hue,
    input  hsv2rgb_pkg::t_chan   i_sat,
    input  hsv2rgb_pkg::t_chan   i_val,
    output hsv2rgb_pkg::t_s1     o_s1
);

    hsv2rgb_pkg::t_s1     r_s1;
    hsv2rgb_pkg::t_s1     n_s1;
    hsv2rgb_pkg::t_sector w_sector;
    logic [8:0]           w_base;
    logic [8:0]           w_diff;

    always_comb begin
        if (i_hue >= 9'(5 * hsv2rgb_pkg::SECTOR_DEG)) begin
            w_sector = hsv2rgb_pkg::SEC_MAG_RED;
            w_base   = 9'(5 * hsv2rgb_pkg::SECTOR_DEG);
        end else if (i_hue >= 9'(4 * hsv2rgb_pkg::SECTOR_DEG)) begin
            w_sector = hsv2rgb_pkg::SEC_BLU_MAG;
            w_base   = 9'(4 * hsv2rgb_pkg::SECTOR_DEG);
        end else if (i_hue >= 9'(3 * hsv2rgb_pkg::SECTOR_DEG)) begin
            w_sector = hsv2rgb_pkg::SEC_CYN_BLU;
            w_base   = 9'(3 * hsv2rgb_pkg::SECTOR_DEG);
        end else if (i_hue >= 9'(2 * hsv2rgb_pkg::SECTOR_DEG)) begin
            w_sector = hsv2rgb_pkg::SEC_GRN_CYN;
            w_base   = 9'(2 * hsv2rgb_pkg::SECTOR_DEG);
        end else if (i_hue >= 9'(hsv2rgb_pkg::SECTOR_DEG)) begin
            w_sector = hsv2rgb_pkg::SEC_YEL_GRN;
            w_base   = 9'(hsv2rgb_pkg::SECTOR_DEG);
        end else begin
            w_sector = hsv2rgb_pkg::SEC_RED_YEL;
            w_base   = 9'd0;
        end
        w_diff = i_hue - w_base;
        n_s1.ok     = (i_hue < 9'(hsv2rgb_pkg::HUE_SPAN));
        n_s1.sector = w_sector;
        n_s1.rem    = w_diff[5:0];
        n_s1.sat    = i_sat;
        n_s1.val    = i_val;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

>>> hdl/hsv2rgb_mul.sv
// ----------------------------------------------------------------------------
// hsv2rgb_mul
// two multiply stages: saturation terms, then the value-scaled numerators
// ----------------------------------------------------------------------------
module hsv2rgb_mul (
    input  logic              i_clk,
    input  logic [1:0]        i_en,
    input  hsv2rgb_pkg::t_s1  i_s1,
    output hsv2rgb_pkg::t_s3  o_s3
);

    typedef struct packed {
        logic                 ok;
        hsv2rgb_pkg::t_sector sector;
        hsv2rgb_pkg::t_chan   val;
        logic [13:0]          sr;
        logic [13:0]          sk;
        logic [15:0]          prod_m;
    } t_s2;

    t_s2              r_s2;
    t_s2              n_s2;
    hsv2rgb_pkg::t_s3 r_s3;
    hsv2rgb_pkg::t_s3 n_s3;
    logic [5:0]       w_rem_k;
    logic [7:0]       w_inv_sat;
    logic [13:0]      w_num_n;
    logic [13:0]      w_num_k;
    logic [31:0]      w_recip_m;

    always_comb begin
        w_rem_k   = 6'(hsv2rgb_pkg::SECTOR_DEG) - i_s1.rem;
        w_inv_sat = 8'(hsv2rgb_pkg::FULL_SCALE) - i_s1.sat;
        n_s2.ok     = i_s1.ok;
        n_s2.sector = i_s1.sector;
        n_s2.val    = i_s1.val;
        n_s2.sr     = 14'(i_s1.sat) * 14'(i_s1.rem);
        n_s2.sk     = 14'(i_s1.sat) * 14'(w_rem_k);
        n_s2.prod_m = 16'(i_s1.val) * 16'(w_inv_sat);
    end

    always_comb begin
        w_num_n   = 14'(hsv2rgb_pkg::SECTOR_DEN) - r_s2.sr;
        w_num_k   = 14'(hsv2rgb_pkg::SECTOR_DEN) - r_s2.sk;
        w_recip_m = 32'(r_s2.prod_m) * 32'(hsv2rgb_pkg::RECIP_255);
        n_s3.ok     = r_s2.ok;
        n_s3.sector = r_s2.sector;
        n_s3.val    = r_s2.val;
        n_s3.m      = w_recip_m[hsv2rgb_pkg::SHIFT_255 +: 8];
        n_s3.prod_n = 22'(r_s2.val) * 22'(w_num_n);
        n_s3.prod_k = 22'(r_s2.val) * 22'(w_num_k);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s2 <= n_s2;
        end
        if (i_en[1]) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

>>> hdl/hsv2rgb_div.sv
// ----------------------------------------------------------------------------
// hsv2rgb_div
// divides by 15300 through a reciprocal with one correction step, then
// routes the channel terms by sector into the output register
// ----------------------------------------------------------------------------
module hsv2rgb_div (
    input  logic               i_clk,
    input  logic [1:0]         i_en,
    input  hsv2rgb_pkg::t_s3   i_s3,
    output hsv2rgb_pkg::t_chan o_red,
    output hsv2rgb_pkg::t_chan o_green,
    output hsv2rgb_pkg::t_chan o_blue
);

    typedef struct packed {
        logic                 ok;
        hsv2rgb_pkg::t_sector sector;
        hsv2rgb_pkg::t_chan   val;
        hsv2rgb_pkg::t_chan   m;
        logic [19:0]          y_n;
        logic [19:0]          y_k;
        hsv2rgb_pkg::t_chan   q_n;
        hsv2rgb_pkg::t_chan   q_k;
    } t_s4;

    t_s4                r_s4;
    t_s4                n_s4;
    hsv2rgb_pkg::t_chan r_red;
    hsv2rgb_pkg::t_chan r_green;
    hsv2rgb_pkg::t_chan r_blue;
    hsv2rgb_pkg::t_chan n_red;
    hsv2rgb_pkg::t_chan n_green;
    hsv2rgb_pkg::t_chan n_blue;
    logic [40:0]        w_est_n;
    logic [40:0]        w_est_k;
    logic [19:0]        w_rem_n;
    logic [19:0]        w_rem_k;
    hsv2rgb_pkg::t_chan w_n;
    hsv2rgb_pkg::t_chan w_k;

    // quotient estimate is exact or one short
    always_comb begin
        n_s4.ok     = i_s3.ok;
        n_s4.sector = i_s3.sector;
        n_s4.val    = i_s3.val;
        n_s4.m      = i_s3.m;
        n_s4.y_n    = i_s3.prod_n[21:2];
        n_s4.y_k    = i_s3.prod_k[21:2];
        w_est_n     = 41'(i_s3.prod_n[21:2]) * 41'(hsv2rgb_pkg::RECIP_QD);
        w_est_k     = 41'(i_s3.prod_k[21:2]) * 41'(hsv2rgb_pkg::RECIP_QD);
        n_s4.q_n    = w_est_n[hsv2rgb_pkg::SHIFT_QD +: 8];
        n_s4.q_k    = w_est_k[hsv2rgb_pkg::SHIFT_QD +: 8];
    end

    always_comb begin
        w_rem_n = r_s4.y_n - 20'(r_s4.q_n) * 20'(hsv2rgb_pkg::QUARTER_DEN);
        w_rem_k = r_s4.y_k - 20'(r_s4.q_k) * 20'(hsv2rgb_pkg::QUARTER_DEN);
        w_n     = r_s4.q_n + 8'(w_rem_n >= 20'(hsv2rgb_pkg::QUARTER_DEN));
        w_k     = r_s4.q_k + 8'(w_rem_k >= 20'(hsv2rgb_pkg::QUARTER_DEN));
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        if (r_s4.ok) begin
            unique case (r_s4.sector)
                hsv2rgb_pkg::SEC_RED_YEL: begin
                    n_red = r_s4.val; n_green = w_k;      n_blue = r_s4.m;
                end
                hsv2rgb_pkg::SEC_YEL_GRN: begin
                    n_red = w_n;      n_green = r_s4.val; n_blue = r_s4.m;
                end
                hsv2rgb_pkg::SEC_GRN_CYN: begin
                    n_red = r_s4.m;   n_green = r_s4.val; n_blue = w_k;
                end
                hsv2rgb_pkg::SEC_CYN_BLU: begin
                    n_red = r_s4.m;   n_green = w_n;      n_blue = r_s4.val;
                end
                hsv2rgb_pkg::SEC_BLU_MAG: begin
                    n_red = w_k;      n_green = r_s4.m;   n_blue = r_s4.val;
                end
                default: begin
                    n_red = r_s4.val; n_green = r_s4.m;   n_blue = w_n;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s4 <= n_s4;
        end
        if (i_en[1]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

>>> hdl/hsv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// streaming hsv to 8-bit rgb colour converter
// ----------------------------------------------------------------------------
// Takes one colour per clock cycle while s_axis_tready is high and delivers
// its rgb result in input order. The five register stages are the
// hue split into sector and offset, the saturation products, the value-scaled
// numerators with the divide by 255, the reciprocal estimate of the divide by
// 15300, and its correction with the sector routing into the output register.
// Each stage holds its own valid bit and moves up whenever the stage after it
// is empty or moving, so a stall at the output only fills empty stages and
// the input keeps taking transfers until the whole pipe is full. A hue of 360
// or more gives black.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // hue[8:0], saturation[16:9], brightness[24:17]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    localparam int unsigned NS = hsv2rgb_pkg::NUM_STAGES;

    logic [NS-1:0]      r_vld;
    logic [NS-1:0]      n_vld;
    logic [NS-1:0]      w_rdy;
    logic               w_in_xfer;
    logic               w_out_xfer;
    hsv2rgb_pkg::t_s1   w_s1;
    hsv2rgb_pkg::t_s3   w_s3;
    hsv2rgb_pkg::t_chan w_red;
    hsv2rgb_pkg::t_chan w_green;
    hsv2rgb_pkg::t_chan w_blue;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        w_rdy[NS-1] = !r_vld[NS-1] || m_axis_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            w_rdy[i] = !r_vld[i] || w_rdy[i+1];
        end
        n_vld[0] = w_rdy[0] ? s_axis_tvalid : r_vld[0];
        for (int i = 1; i < NS; i++) begin
            n_vld[i] = w_rdy[i] ? r_vld[i-1] : r_vld[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer = m_axis_tvalid && m_axis_tready;

    hsv2rgb_sector u_sector (
        .i_clk (i_clk),
        .i_en  (w_rdy[0]),
        .i_hue (s_axis_tdata[8:0]),
        .i_sat (s_axis_tdata[16:9]),
        .i_val (s_axis_tdata[24:17]),
        .o_s1  (w_s1)
    );

    hsv2rgb_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_rdy[2:1]),
        .i_s1  (w_s1),
        .o_s3  (w_s3)
    );

    hsv2rgb_div u_div (
        .i_clk   (i_clk),
        .i_en    (w_rdy[4:3]),
        .i_s3    (w_s3),
        .o_red   (w_red),
        .o_green (w_green),
        .o_blue  (w_blue)
    );

    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_vld[NS-1];
    assign m_axis_tdata  = {w_blue, w_green, w_red};

    // occupancy changes only by transfers in and out
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_vld) == $past($countones(r_vld))
                  + int'($past(w_in_xfer)) - int'($past(w_out_xfer))))
        else $error("pipeline occupancy does not match transfers");

    // an empty output stage means nothing blocks the input
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // an output stall must never drop a pending result
    a_stall_keeps_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result lost or changed");

endmodule
